[rtl/core/touch_button_event_tracker_core_defines.svh]
// Assertion helpers shared by the touch button tracker core.
// Every property is clocked on clk_i and switched off while rst_ni is low.
`ifndef TOUCH_BUTTON_EVENT_TRACKER_CORE_DEFINES_SVH
`define TOUCH_BUTTON_EVENT_TRACKER_CORE_DEFINES_SVH

// Condition that holds in every cycle
`define TBET_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle
`define TBET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/tbet_pkg.sv]
`timescale 1ns / 1ps

package tbet_pkg;

  // Default screen size
  localparam int unsigned SCREEN_WIDTH_DEFAULT  = 240;
  localparam int unsigned SCREEN_HEIGHT_DEFAULT = 320;

  // Field widths
  localparam int unsigned RAW_W      = 10;
  localparam int unsigned PRESS_W    = 12;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned EDGE_W     = 9;
  localparam int unsigned ROT_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned EVENT_W    = 3;
  localparam int unsigned REDRAW_W   = 2;

  // Signed screen coordinate, wide enough for every rotation of the default screen size
  localparam int unsigned COORD_W = 12;

  // Converter calibration window
  localparam int unsigned RAW_X_MIN = 150;
  localparam int unsigned RAW_X_MAX = 920;
  localparam int unsigned RAW_Y_MIN = 120;
  localparam int unsigned RAW_Y_MAX = 940;

  // Pressure window
  localparam int unsigned PRESS_MIN = 10;
  localparam int unsigned PRESS_MAX = 1000;

  // Reciprocal scaling: quotient = (magnitude * k) >> SCALE_SHIFT
  localparam int unsigned SCALE_SHIFT = 20;
  localparam int unsigned SCALE_K_W   = 20;

  // Register reset values
  localparam int unsigned HOLD_THRESHOLD_RESET = 1000;
  localparam int unsigned HOLD_REPEAT_RESET    = 100;

  typedef enum logic [2:0] {
    MODE_ONESHOT       = 3'd0,
    MODE_MEMORY        = 3'd1,
    MODE_TIMER         = 3'd2,
    MODE_ONESHOT_TIMER = 3'd3,
    MODE_MEM_TIMER     = 3'd4
  } mode_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_OFF      = 3'd0,
    EV_ON       = 3'd1,
    EV_PRESSED  = 3'd2,
    EV_RELEASED = 3'd3,
    EV_HOLD     = 3'd4
  } event_e;

  typedef enum logic [REDRAW_W-1:0] {
    RD_NONE     = 2'd0,
    RD_PRESSED  = 2'd1,
    RD_RELEASED = 2'd2
  } redraw_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE           = 3'd0,
    CFG_HOLD_THRESHOLD = 3'd1,
    CFG_HOLD_REPEAT    = 3'd2,
    CFG_LEFT           = 3'd3,
    CFG_TOP            = 3'd4,
    CFG_RIGHT          = 3'd5,
    CFG_BOTTOM         = 3'd6,
    CFG_ROTATION       = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    mode_e             mode;
    logic [MS_W-1:0]   hold_threshold;
    logic [MS_W-1:0]   hold_repeat;
    logic [EDGE_W-1:0] left_edge;
    logic [EDGE_W-1:0] top_edge;
    logic [EDGE_W-1:0] right_edge;
    logic [EDGE_W-1:0] bottom_edge;
    logic [ROT_W-1:0]  rotation;
  } cfg_t;

endpackage

[rtl/core/touch_button_event_tracker_core.sv]
`timescale 1ns / 1ps
`include "touch_button_event_tracker_core_defines.svh"
// A sample transferred in is held in the sample register; its result moves into the output
// register when the result side can take it and is then offered on the result channel.
// Throughput: 1 sample per cycle while out_stall_i is low; the sample and result registers
// each hold one item and the mapping multiply plus state update sit between them.
// Reset (rst_ni low, asynchronous): pipeline empty, held flag and timers cleared,
// registers at mode one-shot, hold level 1000 ms, repeat 100 ms, edges and rotation 0.
module touch_button_event_tracker_core #(
  parameter int unsigned SCREEN_WIDTH  = tbet_pkg::SCREEN_WIDTH_DEFAULT,
  parameter int unsigned SCREEN_HEIGHT = tbet_pkg::SCREEN_HEIGHT_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tbet_pkg::RAW_W-1:0]      raw_x_i,
  input  logic [tbet_pkg::RAW_W-1:0]      raw_y_i,
  input  logic [tbet_pkg::PRESS_W-1:0]    pressure_i,
  input  logic                            release_confirmed_i,
  input  logic [tbet_pkg::TIME_W-1:0]     now_ms_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tbet_pkg::EVENT_W-1:0]    event_res_o,
  output logic [tbet_pkg::REDRAW_W-1:0]   redraw_o,
  // register write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tbet_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tbet_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tbet_pkg::*;

  cfg_t cfg;

  logic               s1_valid_q, s1_valid_d;
  logic [RAW_W-1:0]   raw_x_q, raw_y_q;
  logic [PRESS_W-1:0] pressure_q;
  logic               confirmed_q;
  logic [TIME_W-1:0]  now_q;

  logic               out_valid_q, out_valid_d;
  event_e             event_q, event_d;
  redraw_e            redraw_q, redraw_d;

  logic               in_xfer, out_load, s1_adv, in_rect;

  // Handshake control
  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign s1_valid_d  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_load ? s1_valid_q : out_valid_q;

  tbet_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tbet_map #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_map (
    .raw_x_i   (raw_x_q),
    .raw_y_i   (raw_y_q),
    .cfg_i     (cfg),
    .in_rect_o (in_rect)
  );

  tbet_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (s1_adv),
    .in_rect_i   (in_rect),
    .pressure_i  (pressure_q),
    .confirmed_i (confirmed_q),
    .now_i       (now_q),
    .cfg_i       (cfg),
    .event_o     (event_d),
    .redraw_o    (redraw_d)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sample register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      raw_x_q     <= raw_x_i;
      raw_y_q     <= raw_y_i;
      pressure_q  <= pressure_i;
      confirmed_q <= release_confirmed_i;
      now_q       <= now_ms_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      event_q  <= event_d;
      redraw_q <= redraw_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_q;
  assign redraw_o    = redraw_q;

  `TBET_ASSERT(a_stall_only_when_blocked, !in_stall_o || (out_valid_o && out_stall_i), "input stalled while result side free")
  `TBET_ASSERT_NEXT(a_sample_drains, s1_valid_q && !out_valid_q, out_valid_q, "sample did not reach result register")

endmodule

[rtl/core/tbet_cfg.sv]
`timescale 1ns / 1ps

module tbet_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [tbet_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tbet_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output tbet_pkg::cfg_t                 cfg_o
);
  import tbet_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register write decode; out-of-range mode codes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MODE: begin
          if (cfg_data_i[2:0] <= MODE_MEM_TIMER) begin
            cfg_d.mode = mode_e'(cfg_data_i[2:0]);
          end
        end
        CFG_HOLD_THRESHOLD: cfg_d.hold_threshold = cfg_data_i[MS_W-1:0];
        CFG_HOLD_REPEAT:    cfg_d.hold_repeat    = cfg_data_i[MS_W-1:0];
        CFG_LEFT:           cfg_d.left_edge      = cfg_data_i[EDGE_W-1:0];
        CFG_TOP:            cfg_d.top_edge       = cfg_data_i[EDGE_W-1:0];
        CFG_RIGHT:          cfg_d.right_edge     = cfg_data_i[EDGE_W-1:0];
        CFG_BOTTOM:         cfg_d.bottom_edge    = cfg_data_i[EDGE_W-1:0];
        CFG_ROTATION:       cfg_d.rotation       = cfg_data_i[ROT_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode           <= MODE_ONESHOT;
      cfg_q.hold_threshold <= MS_W'(HOLD_THRESHOLD_RESET);
      cfg_q.hold_repeat    <= MS_W'(HOLD_REPEAT_RESET);
      cfg_q.left_edge      <= '0;
      cfg_q.top_edge       <= '0;
      cfg_q.right_edge     <= '0;
      cfg_q.bottom_edge    <= '0;
      cfg_q.rotation       <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/tbet_map.sv]
`timescale 1ns / 1ps

module tbet_map #(
  parameter int unsigned SCREEN_WIDTH  = tbet_pkg::SCREEN_WIDTH_DEFAULT,
  parameter int unsigned SCREEN_HEIGHT = tbet_pkg::SCREEN_HEIGHT_DEFAULT
) (
  input  logic [tbet_pkg::RAW_W-1:0] raw_x_i,
  input  logic [tbet_pkg::RAW_W-1:0] raw_y_i,
  input  tbet_pkg::cfg_t             cfg_i,
  output logic                       in_rect_o
);
  import tbet_pkg::*;

  localparam int unsigned XSpan = RAW_X_MAX - RAW_X_MIN;
  localparam int unsigned YSpan = RAW_Y_MAX - RAW_Y_MIN;
  localparam longint unsigned KxFull =
    ((longint'(SCREEN_WIDTH) << SCALE_SHIFT) + longint'(XSpan) - 1) / longint'(XSpan);
  localparam longint unsigned KyFull =
    ((longint'(SCREEN_HEIGHT) << SCALE_SHIFT) + longint'(YSpan) - 1) / longint'(YSpan);
  localparam logic [SCALE_K_W-1:0] KX = SCALE_K_W'(KxFull);
  localparam logic [SCALE_K_W-1:0] KY = SCALE_K_W'(KyFull);
  localparam logic signed [COORD_W-1:0] WIDTH_S  = COORD_W'(SCREEN_WIDTH);
  localparam logic signed [COORD_W-1:0] HEIGHT_S = COORD_W'(SCREEN_HEIGHT);
  localparam int unsigned PROD_W = RAW_W + SCALE_K_W;

  // span + trunc((raw - lo) * -span / range), quotient by reciprocal multiply
  function automatic logic signed [COORD_W-1:0] scale_axis(
    input logic [RAW_W-1:0]          raw,
    input logic [RAW_W-1:0]          lo,
    input logic [SCALE_K_W-1:0]      k,
    input logic signed [COORD_W-1:0] span
  );
    logic signed [RAW_W:0]        n;
    logic signed [RAW_W:0]        n_neg;
    logic [RAW_W-1:0]             mag;
    logic [PROD_W-1:0]            prod;
    logic [RAW_W-1:0]             q;
    logic signed [COORD_W-1:0]    qs;
    n     = $signed({1'b0, raw}) - $signed({1'b0, lo});
    n_neg = -n;
    mag   = n[RAW_W] ? n_neg[RAW_W-1:0] : n[RAW_W-1:0];
    prod  = PROD_W'(mag) * PROD_W'(k);
    q     = prod[PROD_W-1 -: RAW_W];
    qs    = $signed(COORD_W'(q));
    return n[RAW_W] ? (span + qs) : (span - qs);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_axis(
    input logic signed [COORD_W-1:0] v,
    input logic signed [COORD_W-1:0] hi
  );
    logic signed [COORD_W-1:0] r;
    r = v;
    if (v < 0) begin
      r = '0;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  logic signed [COORD_W-1:0] tx, ty, dx, dy;
  logic signed [COORD_W-1:0] left_s, top_s, right_s, bottom_s;

  assign tx = scale_axis(raw_x_i, RAW_W'(RAW_X_MIN), KX, WIDTH_S);
  assign ty = scale_axis(raw_y_i, RAW_W'(RAW_Y_MIN), KY, HEIGHT_S);

  // Rotation select
  always_comb begin
    case (cfg_i.rotation)
      2'd0: begin
        dx = clamp_axis(tx, WIDTH_S);
        dy = clamp_axis(ty, HEIGHT_S);
      end
      2'd1: begin
        dx = ty;
        dy = tx;
      end
      2'd2: begin
        dx = WIDTH_S - clamp_axis(tx, WIDTH_S);
        dy = HEIGHT_S - clamp_axis(ty, HEIGHT_S);
      end
      default: begin
        dx = WIDTH_S - ty;
        dy = HEIGHT_S - tx;
      end
    endcase
  end

  // Strict rectangle test, signed
  assign left_s   = COORD_W'(cfg_i.left_edge);
  assign top_s    = COORD_W'(cfg_i.top_edge);
  assign right_s  = COORD_W'(cfg_i.right_edge);
  assign bottom_s = COORD_W'(cfg_i.bottom_edge);

  assign in_rect_o = (left_s < dx) && (dx < right_s) && (top_s < dy) && (dy < bottom_s);

endmodule

[rtl/core/tbet_fsm.sv]
`timescale 1ns / 1ps
`include "touch_button_event_tracker_core_defines.svh"

module tbet_fsm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         upd_i,
  input  logic                         in_rect_i,
  input  logic [tbet_pkg::PRESS_W-1:0] pressure_i,
  input  logic                         confirmed_i,
  input  logic [tbet_pkg::TIME_W-1:0]  now_i,
  input  tbet_pkg::cfg_t               cfg_i,
  output tbet_pkg::event_e             event_o,
  output tbet_pkg::redraw_e            redraw_o
);
  import tbet_pkg::*;

  logic              held_q, held_d;
  logic [TIME_W-1:0] hold_start_q, hold_start_d;
  logic [TIME_W-1:0] repeat_start_q, repeat_start_d;

  logic              hit, in_window, do_release, keeps_timers;
  logic              hold_due, repeat_due;
  logic [TIME_W-1:0] hold_mark, repeat_level;
  event_e            fresh_ev, before_ev;

  // Pressure windows: strict for a hit, inclusive for a slide-off
  assign hit       = in_rect_i && (pressure_i > PRESS_W'(PRESS_MIN))
                                && (pressure_i < PRESS_W'(PRESS_MAX));
  assign in_window = (pressure_i >= PRESS_W'(PRESS_MIN)) && (pressure_i <= PRESS_W'(PRESS_MAX));
  assign do_release = !hit && (((pressure_i == '0) && confirmed_i) || in_window);

  // Timer levels wrap at 32 bits
  assign hold_mark    = hold_start_q + TIME_W'(cfg_i.hold_threshold);
  assign repeat_level = repeat_start_q + TIME_W'(cfg_i.hold_repeat);
  assign hold_due     = now_i > hold_mark;
  assign repeat_due   = now_i > repeat_level;

  assign fresh_ev  = (cfg_i.mode == MODE_MEM_TIMER) ? EV_PRESSED : EV_ON;
  assign before_ev = (cfg_i.mode == MODE_ONESHOT_TIMER) ? EV_OFF : EV_ON;

  always_comb begin
    case (cfg_i.mode) inside
      MODE_MEMORY, MODE_MEM_TIMER: keeps_timers = 1'b1;
      default:                     keeps_timers = 1'b0;
    endcase
  end

  // Button state and event
  always_comb begin
    held_d         = held_q;
    hold_start_d   = hold_start_q;
    repeat_start_d = repeat_start_q;
    event_o        = held_q ? EV_ON : EV_OFF;
    redraw_o       = RD_NONE;
    if (hit) begin
      held_d = 1'b1;
      if (!held_q) begin
        redraw_o = RD_PRESSED;
      end
      case (cfg_i.mode)
        MODE_ONESHOT: event_o = held_q ? EV_OFF : EV_ON;
        MODE_MEMORY:  event_o = held_q ? EV_ON : EV_PRESSED;
        default: begin
          if (held_q) begin
            if (hold_due) begin
              if (repeat_due) begin
                repeat_start_d = now_i;
                event_o        = EV_HOLD;
              end else begin
                event_o = EV_OFF;
              end
            end else begin
              event_o = before_ev;
            end
          end else begin
            hold_start_d   = now_i;
            repeat_start_d = now_i;
            event_o        = fresh_ev;
          end
        end
      endcase
    end else if (do_release) begin
      held_d = 1'b0;
      if (held_q) begin
        redraw_o = RD_RELEASED;
      end
      if (held_q && keeps_timers) begin
        event_o = EV_RELEASED;
      end else begin
        hold_start_d   = now_i;
        repeat_start_d = now_i;
        event_o        = EV_OFF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q         <= 1'b0;
      hold_start_q   <= '0;
      repeat_start_q <= '0;
    end else if (upd_i) begin
      held_q         <= held_d;
      hold_start_q   <= hold_start_d;
      repeat_start_q <= repeat_start_d;
    end
  end

  `TBET_ASSERT_NEXT(a_hit_sets_held, upd_i && hit, held_q, "hit did not set held flag")
  `TBET_ASSERT_NEXT(a_release_clears_held, upd_i && do_release, !held_q, "release kept held")
  `TBET_ASSERT(a_released_only_memory, (event_o != EV_RELEASED) || keeps_timers, "bad release")
  `TBET_ASSERT_NEXT(a_hold_restarts_repeat, upd_i && (event_o == EV_HOLD), repeat_start_q == $past(now_i), "hold event did not restart repeat timer")

endmodule

[sim/tbet_checker.sv]
`timescale 1ns / 1ps

// Watches the sample, result and register channels of the touch button tracker,
// predicts one event and redraw code per sample transfer and checks every result.
module tbet_checker
  import tbet_pkg::*;
#(
  parameter int SCREEN_W = 240,
  parameter int SCREEN_H = 320
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [RAW_W-1:0]      raw_x_i,
  input  logic [RAW_W-1:0]      raw_y_i,
  input  logic [PRESS_W-1:0]    pressure_i,
  input  logic                  release_confirmed_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [EVENT_W-1:0]    event_res_i,
  input  logic [REDRAW_W-1:0]   redraw_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  cfg_idx_e              cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    fail_count_o
);

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;

  typedef struct {
    event_e  ev;
    redraw_e rd;
  } outcome_t;

  // Button registers as last written
  mode_e             cfg_mode     = MODE_ONESHOT;
  logic [MS_W-1:0]   cfg_hold_lvl = MS_W'(HOLD_THRESHOLD_RESET);
  logic [MS_W-1:0]   cfg_repeat   = MS_W'(HOLD_REPEAT_RESET);
  logic [EDGE_W-1:0] cfg_left     = '0;
  logic [EDGE_W-1:0] cfg_top      = '0;
  logic [EDGE_W-1:0] cfg_right    = '0;
  logic [EDGE_W-1:0] cfg_bottom   = '0;
  logic [ROT_W-1:0]  cfg_rot      = '0;

  // Button state
  bit                held         = 1'b0;
  logic [TIME_W-1:0] hold_t0      = '0;
  logic [TIME_W-1:0] repeat_t0    = '0;

  outcome_t predicted_events[$];
  int       fails = 0;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  // Raw converter reading to screen axis, truncating toward zero
  function automatic int to_screen(int raw, int lo, int hi, int span);
    return span + ((raw - lo) * (-span)) / (hi - lo);
  endfunction

  function automatic int clip(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Release or slide-off: memory modes report the release of a held button and keep the timers
  function automatic event_e let_go(input logic [TIME_W-1:0] now, inout redraw_e rd);
    bit was;
    was  = held;
    held = 1'b0;
    if (was) rd = RD_RELEASED;
    if (was && (cfg_mode == MODE_MEMORY || cfg_mode == MODE_MEM_TIMER)) return EV_RELEASED;
    hold_t0   = now;
    repeat_t0 = now;
    return EV_OFF;
  endfunction

  // Held in a timed mode: hold once past the level and the repeat interval
  function automatic event_e hold_due(input logic [TIME_W-1:0] now, input event_e early);
    logic [TIME_W-1:0] lvl_end;
    logic [TIME_W-1:0] rep_end;
    lvl_end = hold_t0 + TIME_W'(cfg_hold_lvl);
    rep_end = repeat_t0 + TIME_W'(cfg_repeat);
    if (now > lvl_end) begin
      if (now > rep_end) begin
        repeat_t0 = now;
        return EV_HOLD;
      end
      return EV_OFF;
    end
    return early;
  endfunction

  function automatic void predict_event(input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry,
                                        input logic [PRESS_W-1:0] z, input logic confirmed,
                                        input logic [TIME_W-1:0] now);
    int       tx;
    int       ty;
    int       sx;
    int       sy;
    bit       hit;
    bit       was;
    outcome_t res;
    tx = to_screen(int'(rx), RAW_X_MIN, RAW_X_MAX, SCREEN_W);
    ty = to_screen(int'(ry), RAW_Y_MIN, RAW_Y_MAX, SCREEN_H);
    case (cfg_rot)
      ROT_0: begin
        sx = clip(tx, SCREEN_W);
        sy = clip(ty, SCREEN_H);
      end
      ROT_90: begin
        sx = ty;
        sy = tx;
      end
      ROT_180: begin
        sx = SCREEN_W - clip(tx, SCREEN_W);
        sy = SCREEN_H - clip(ty, SCREEN_H);
      end
      default: begin
        sx = SCREEN_W - ty;
        sy = SCREEN_H - tx;
      end
    endcase
    hit = int'(cfg_left) < sx && sx < int'(cfg_right) &&
          int'(cfg_top) < sy && sy < int'(cfg_bottom) &&
          z > PRESS_MIN && z < PRESS_MAX;
    res.rd = RD_NONE;
    if (hit) begin
      was  = held;
      held = 1'b1;
      if (!was) res.rd = RD_PRESSED;
      case (cfg_mode)
        MODE_ONESHOT: res.ev = was ? EV_OFF : EV_ON;
        MODE_MEMORY:  res.ev = was ? EV_ON : EV_PRESSED;
        default: begin
          if (was) begin
            res.ev = hold_due(now, (cfg_mode == MODE_ONESHOT_TIMER) ? EV_OFF : EV_ON);
          end else begin
            hold_t0   = now;
            repeat_t0 = now;
            res.ev    = (cfg_mode == MODE_MEM_TIMER) ? EV_PRESSED : EV_ON;
          end
        end
      endcase
    end else if (z == 0) begin
      if (confirmed) res.ev = let_go(now, res.rd);
      else res.ev = held ? EV_ON : EV_OFF;
    end else if (z >= PRESS_MIN && z <= PRESS_MAX) begin
      res.ev = let_go(now, res.rd);
    end else begin
      res.ev = held ? EV_ON : EV_OFF;
    end
    predicted_events.push_back(res);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      cfg_mode     = MODE_ONESHOT;
      cfg_hold_lvl = MS_W'(HOLD_THRESHOLD_RESET);
      cfg_repeat   = MS_W'(HOLD_REPEAT_RESET);
      cfg_left     = '0;
      cfg_top      = '0;
      cfg_right    = '0;
      cfg_bottom   = '0;
      cfg_rot      = '0;
      held         = 1'b0;
      hold_t0      = '0;
      repeat_t0    = '0;
      predicted_events.delete();
      pending_o <= 0;
    end else begin
      // result transfer against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (predicted_events.size() == 0) begin
          $error("result transfer with no sample outstanding: event_res %0d, redraw %0d",
                 event_res_i, redraw_i);
          fails++;
        end else begin
          want = predicted_events.pop_front();
          if (event_res_i !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, event_res_i);
            fails++;
          end
          if (redraw_i !== want.rd) begin
            $error("redraw: expected %0d, got %0d", want.rd, redraw_i);
            fails++;
          end
        end
      end

      // register write; out-of-range modes leave the mode as it was
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MODE: begin
            if (cfg_data_i[2:0] <= MODE_MEM_TIMER) cfg_mode = mode_e'(cfg_data_i[2:0]);
          end
          CFG_HOLD_THRESHOLD: cfg_hold_lvl = cfg_data_i[MS_W-1:0];
          CFG_HOLD_REPEAT:    cfg_repeat   = cfg_data_i[MS_W-1:0];
          CFG_LEFT:           cfg_left     = cfg_data_i[EDGE_W-1:0];
          CFG_TOP:            cfg_top      = cfg_data_i[EDGE_W-1:0];
          CFG_RIGHT:          cfg_right    = cfg_data_i[EDGE_W-1:0];
          CFG_BOTTOM:         cfg_bottom   = cfg_data_i[EDGE_W-1:0];
          default:            cfg_rot      = cfg_data_i[ROT_W-1:0];
        endcase
      end

      // sample transfer
      if (in_valid_i && !in_stall_i) begin
        predict_event(raw_x_i, raw_y_i, pressure_i, release_confirmed_i, now_ms_i);
      end

      pending_o <= predicted_events.size();
    end
    fail_count_o <= fails;
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tbet_pkg::*;

  localparam int LIMIT       = 200000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 50;
  localparam int HOLD_PHASE  = 1;
  localparam int HOLD_CYCLES = 80;
  localparam int CX          = 535;  // lands mid-screen at rotations 0 and 2, off-centre at 1 and 3
  localparam int CY          = 530;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_e;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic [RAW_W-1:0]      raw_x     = '0;
  logic [RAW_W-1:0]      raw_y     = '0;
  logic [PRESS_W-1:0]    pressure  = '0;
  logic                  confirmed = 1'b0;
  logic [TIME_W-1:0]     now_ms    = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [EVENT_W-1:0]    event_res;
  logic [REDRAW_W-1:0]   redraw;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_e              cfg_index = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int                pending;
  int                fail_count;
  int                cycles        = 0;
  int                phase_no      = -1;
  int                sent_in_phase = 0;
  int                burst_left    = 0;
  bit                gaps_on       = 1'b1;
  int                step_max      = 300;
  logic [TIME_W-1:0] ms_time       = '0;

  // receiver pattern state, owned by the receiver process
  stall_style_e      stall_style   = STALL_NONE;
  int                stall_left    = 0;
  int                hold_left     = 0;
  bit                hold_done     = 1'b0;

  touch_button_event_tracker_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .raw_x_i            (raw_x),
    .raw_y_i            (raw_y),
    .pressure_i         (pressure),
    .release_confirmed_i(confirmed),
    .now_ms_i           (now_ms),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .event_res_o        (event_res),
    .redraw_o           (redraw),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  tbet_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .raw_x_i            (raw_x),
    .raw_y_i            (raw_y),
    .pressure_i         (pressure),
    .release_confirmed_i(confirmed),
    .now_ms_i           (now_ms),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .event_res_i        (event_res),
    .redraw_i           (redraw),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .pending_o          (pending),
    .fail_count_o       (fail_count)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Result side: one long hold-off in its phase, otherwise changing stall patterns
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (phase_no == HOLD_PHASE && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (stall_left == 0) begin
          stall_style = stall_style_e'($urandom_range(0, 3));
          stall_left  = $urandom_range(10, 120);
        end
        stall_left--;
        case (stall_style)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= stall_left[0];
        endcase
      end
    end
  end

  // one register write; valid is left high for a following write
  task automatic reg_write(input cfg_idx_e idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic program_button(input mode_e mode, input int bad_mode, input int lvl,
                                input int rep, input int l, input int t, input int r,
                                input int b, input int rot);
    reg_write(CFG_MODE, int'(mode));
    if (bad_mode != 0) reg_write(CFG_MODE, bad_mode);
    reg_write(CFG_HOLD_THRESHOLD, lvl);
    reg_write(CFG_HOLD_REPEAT, rep);
    reg_write(CFG_LEFT, l);
    reg_write(CFG_TOP, t);
    reg_write(CFG_RIGHT, r);
    reg_write(CFG_BOTTOM, b);
    reg_write(CFG_ROTATION, rot);
    cfg_valid <= 1'b0;
  endtask

  // wait for every outstanding result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // one sample transfer, with a random gap at the start of each burst while gaps are on
  task automatic offer(input int rx, input int ry, input int z, input bit c,
                       input logic [TIME_W-1:0] t);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_valid  <= 1'b1;
    raw_x     <= rx[RAW_W-1:0];
    raw_y     <= ry[RAW_W-1:0];
    pressure  <= z[PRESS_W-1:0];
    confirmed <= c;
    now_ms    <= t;
    do @(posedge clk_i); while (in_stall);
    sent_in_phase++;
  endtask

  // finger down near one spot, some bounce and noise, then release or slide off
  task automatic stroke();
    int bx;
    int by;
    int n;
    int pick;
    bx = $urandom_range(RAW_X_MIN, RAW_X_MAX);
    by = $urandom_range(RAW_Y_MIN, RAW_Y_MAX);
    n  = $urandom_range(3, 15);
    repeat (n) begin
      ms_time += $urandom_range(0, step_max);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        offer(bx, by, $urandom_range(0, 1) ? $urandom_range(1, PRESS_MIN - 1)
                                           : $urandom_range(PRESS_MAX + 1, 4095),
              1'($urandom_range(0, 1)), ms_time);
      end else if (pick == 1) begin
        offer(bx, by, 0, 1'b0, ms_time);
      end else begin
        offer(bx - 2 + int'($urandom_range(0, 4)), by - 2 + int'($urandom_range(0, 4)),
              $urandom_range(PRESS_MIN + 1, PRESS_MAX - 1), 1'($urandom_range(0, 1)),
              ms_time);
      end
    end
    ms_time += $urandom_range(0, step_max);
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      offer(bx, by, 0, 1'b1, ms_time);
    end else if (pick == 1) begin
      offer($urandom_range(0, 1) ? 0 : 1023, $urandom_range(0, 1) ? 0 : 1023,
            $urandom_range(PRESS_MIN, PRESS_MAX), 1'($urandom_range(0, 1)), ms_time);
    end else begin
      offer(bx, by, 0, 1'b1, ms_time);
      ms_time += 1;
      offer(bx, by, 0, 1'b1, ms_time);
    end
  endtask

  // any field value, now and then at a random time
  task automatic noise();
    logic [TIME_W-1:0] t;
    t = ($urandom_range(0, 9) == 0) ? $urandom() : ms_time;
    offer($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 4095),
          1'($urandom_range(0, 1)), t);
  endtask

  initial begin : stimulus
    mode_e m;
    int    bad;
    int    lvl;
    int    rep;
    int    l;
    int    t;
    int    r;
    int    b;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Timer mode; a later out-of-range mode write must not take effect
    program_button(MODE_TIMER, 6, 5, 2, 10, 10, 230, 310, 0);
    offer(0, 0, 0, 1'b0, 0);
    offer(1023, 1023, 4095, 1'b1, 32'hFFFF_FFFF);
    offer(CX, CY, PRESS_MIN, 1'b0, 50);
    offer(CX, CY, PRESS_MAX, 1'b1, 60);
    offer(CX, CY, PRESS_MIN + 1, 1'b0, 100);
    offer(CX, CY, PRESS_MAX - 1, 1'b0, 103);
    offer(CX, CY, 500, 1'b1, 106);
    offer(CX, CY, 500, 1'b0, 107);
    offer(CX, CY, 500, 1'b0, 109);
    offer(CX, CY, PRESS_MIN - 1, 1'b0, 110);
    offer(CX, CY, PRESS_MAX + 1, 1'b0, 111);
    offer(CX, CY, 0, 1'b0, 112);
    offer(CX, CY, 0, 1'b1, 113);
    offer(1023, CY, 500, 1'b0, 114);
    settle();

    // Memory mode, rotated: press, stay, slide off, press, lift
    program_button(MODE_MEMORY, 0, 0, 0, 10, 10, 230, 310, 3);
    offer(CX, CY, 500, 1'b0, 200);
    offer(CX, CY, 500, 1'b1, 201);
    offer(1023, CY, 500, 1'b0, 202);
    offer(CX, CY, 500, 1'b0, 203);
    offer(CX, CY, 0, 1'b1, 204);
    settle();

    // Memory timer with zero level and interval: press, hold, release
    program_button(MODE_MEM_TIMER, 0, 0, 0, 10, 10, 230, 310, 2);
    offer(CX, CY, 500, 1'b0, 300);
    offer(CX, CY, 500, 1'b0, 301);
    offer(CX, CY, 0, 1'b1, 302);

    // Random phases: each mode twice, every rotation, extreme levels and edges
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      m   = mode_e'(p % 5);
      bad = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 7) : 0;
      lvl = (p == 3) ? 0 : (p == 7) ? 65535 : $urandom_range(0, 800);
      rep = (p == 4) ? 0 : (p == 8) ? 65535 : $urandom_range(0, 250);
      if (p == 9) begin
        l = $urandom_range(0, 511);
        t = $urandom_range(0, 511);
        r = $urandom_range(0, 511);
        b = $urandom_range(0, 511);
      end else if (p == 6) begin
        l = 0;
        t = 0;
        r = 511;
        b = 511;
      end else begin
        l = $urandom_range(0, 60);
        t = $urandom_range(0, 60);
        r = $urandom_range(180, 511);
        b = $urandom_range(260, 511);
      end
      program_button(m, bad, lvl, rep, l, t, r, b, p % 4);
      gaps_on = (p != 2);
      // run the clock across the 32-bit wrap
      if (p == 5) ms_time = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      sent_in_phase = 0;
      phase_no      = p;
      while (sent_in_phase < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) stroke();
        else noise();
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[touch_button_event_tracker_core.f]
+incdir+rtl/core
rtl/core/tbet_pkg.sv
rtl/core/tbet_cfg.sv
rtl/core/tbet_map.sv
rtl/core/tbet_fsm.sv
rtl/core/touch_button_event_tracker_core.sv
sim/tbet_checker.sv
sim/tb_top.sv
